// ----- hdl/oid_arc_base128_encoder_core_macros.svh -----
// assertion macros shared by the encoder modules
`ifndef OID_ARC_BASE128_ENCODER_CORE_MACROS_SVH
`define OID_ARC_BASE128_ENCODER_CORE_MACROS_SVH

// checked on every rising edge outside reset
`define OABE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define OABE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/oabe_pkg.sv -----
// types and constants of the object identifier arc encoder
package oabe_pkg;

  localparam int ARC_W = 31;
  localparam int NGRP  = (ARC_W + 6) / 7;
  localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PAD_W = NGRP * 7;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_FIRST  = 2'd1;
  localparam logic [1:0] ERR_SECOND = 2'd2;
  localparam logic [1:0] ERR_ORPHAN = 2'd3;

  localparam logic [ARC_W-1:0] FIRST_MAX  = ARC_W'(2);
  localparam logic [ARC_W-1:0] SECOND_MAX = ARC_W'(39);

  typedef struct packed {
    logic [ARC_W-1:0] arc_value;
    logic             first_arc;
    logic             last_arc;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       ends_identifier;
    logic [1:0] error_code;
  } out_item_t;

  // one number to emit, or one error beat
  typedef struct packed {
    logic [ARC_W-1:0] value;
    logic [GRP_W-1:0] top_grp;
    logic             ends;
    logic [1:0]       code;
  } job_t;

endpackage

// ----- hdl/oabe_front.sv -----
// front end: identifier tracking, arc range checks and job building
module oabe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  oabe_pkg::in_item_t  item,
  output logic                job_push,
  output oabe_pkg::job_t      job
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HELD,
    PH_REST
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [1:0] held_r, held_nxt;
  logic       disc_r, disc_nxt;

  logic                         emit;
  logic [oabe_pkg::ARC_W-1:0]   value;
  logic                         ends;
  logic [1:0]                   code;
  logic [oabe_pkg::PAD_W-1:0]   pad;
  logic [oabe_pkg::GRP_W-1:0]   top;
  logic                         arc_lo_ok;
  logic                         arc_mid_ok;

  assign arc_lo_ok  = item.arc_value <= oabe_pkg::FIRST_MAX;
  assign arc_mid_ok = item.arc_value <= oabe_pkg::SECOND_MAX;

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    disc_nxt  = disc_r;
    emit      = 1'b0;
    value     = '0;
    ends      = 1'b0;
    code      = oabe_pkg::ERR_NONE;
    if (item.first_arc) begin
      disc_nxt  = 1'b0;
      phase_nxt = PH_IDLE;
      if (!arc_lo_ok) begin
        disc_nxt = !item.last_arc;
        emit     = 1'b1;
        ends     = 1'b1;
        code     = oabe_pkg::ERR_FIRST;
      end else if (item.last_arc) begin
        emit  = 1'b1;
        ends  = 1'b1;
        value = oabe_pkg::ARC_W'({item.arc_value[1:0], 5'b0})
              + oabe_pkg::ARC_W'({item.arc_value[1:0], 3'b0});
      end else begin
        held_nxt  = item.arc_value[1:0];
        phase_nxt = PH_HELD;
      end
    end else if (disc_r) begin
      if (item.last_arc) begin
        disc_nxt = 1'b0;
      end
    end else begin
      case (phase_r)
        PH_HELD: begin
          emit = 1'b1;
          if (!arc_mid_ok) begin
            phase_nxt = PH_IDLE;
            disc_nxt  = !item.last_arc;
            ends      = 1'b1;
            code      = oabe_pkg::ERR_SECOND;
          end else begin
            phase_nxt = item.last_arc ? PH_IDLE : PH_REST;
            ends      = item.last_arc;
            value     = oabe_pkg::ARC_W'({held_r, 5'b0})
                      + oabe_pkg::ARC_W'({held_r, 3'b0}) + item.arc_value;
          end
        end
        PH_REST: begin
          emit  = 1'b1;
          ends  = item.last_arc;
          value = item.arc_value;
          if (item.last_arc) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          emit = 1'b1;
          ends = 1'b1;
          code = oabe_pkg::ERR_ORPHAN;
        end
      endcase
    end
  end

  // index of the most significant non-zero group
  assign pad = oabe_pkg::PAD_W'(value);

  always_comb begin
    top = '0;
    for (int g = 1; g < oabe_pkg::NGRP; g++) begin
      if (pad[7*g +: 7] != 7'd0) begin
        top = oabe_pkg::GRP_W'(g);
      end
    end
  end

  assign job_push    = accept && emit;
  assign job.value   = value;
  assign job.top_grp = top;
  assign job.ends    = ends;
  assign job.code    = code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 2'd0;
      disc_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      disc_r  <= disc_nxt;
    end
  end

endmodule

// ----- hdl/oabe_fifo.sv -----
// short job queue between front and back end
`include "oid_arc_base128_encoder_core_macros.svh"

module oabe_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  oabe_pkg::job_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output oabe_pkg::job_t rdata
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  oabe_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0]  wptr_r, wptr_nxt;
  logic [PW-1:0]  rptr_r, rptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push;
  logic           do_pop;

  assign full    = cnt_r == CW'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  `OABE_ASSERT(a_cnt_bound, cnt_r <= CW'(DEPTH), "queue count above depth")
  `OABE_ASSERT(a_no_push_full, push |-> !full, "job pushed into a full queue")
  `OABE_ASSERT(a_cnt_up, (do_push && !do_pop) |=> cnt_r == $past(cnt_r) + 1'b1, "count missed")

endmodule

// ----- hdl/oabe_back.sv -----
// back end: splits each job into base-128 bytes into the result register
`include "oid_arc_base128_encoder_core_macros.svh"

module oabe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_empty,
  input  oabe_pkg::job_t      job,
  output logic                job_pop,
  input  logic                pop,
  output logic                empty,
  output oabe_pkg::out_item_t out_item
);

  oabe_pkg::job_t             job_r, job_nxt;
  logic [oabe_pkg::GRP_W-1:0] grp_r, grp_nxt;
  logic                       busy_r, busy_nxt;
  logic                       ovld_r, ovld_nxt;
  oabe_pkg::out_item_t        out_r, out_nxt;

  logic [oabe_pkg::PAD_W-1:0] pad;
  logic [6:0]                 grp [oabe_pkg::NGRP];
  logic                       slot_free;
  logic                       emit;
  logic                       done;
  logic                       take;

  assign pad = oabe_pkg::PAD_W'(job_r.value);

  always_comb begin
    for (int g = 0; g < oabe_pkg::NGRP; g++) begin
      grp[g] = pad[7*g +: 7];
    end
  end

  assign slot_free = !ovld_r || pop;
  assign emit      = busy_r && slot_free;
  assign done      = emit && (grp_r == '0);
  assign take      = !job_empty && (!busy_r || done);
  assign job_pop   = take;

  always_comb begin
    job_nxt  = job_r;
    grp_nxt  = grp_r;
    busy_nxt = busy_r;
    if (take) begin
      job_nxt  = job;
      grp_nxt  = job.top_grp;
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (emit) begin
      grp_nxt = grp_r - 1'b1;
    end
  end

  always_comb begin
    ovld_nxt = ovld_r;
    out_nxt  = out_r;
    if (emit) begin
      ovld_nxt                = 1'b1;
      out_nxt.out_byte        = {grp_r != '0, grp[grp_r]};
      out_nxt.last_of_run     = grp_r == '0;
      out_nxt.ends_identifier = job_r.ends;
      out_nxt.error_code      = job_r.code;
    end else if (pop) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    grp_r <= grp_nxt;
    out_r <= out_nxt;
  end

  assign empty    = !ovld_r;
  assign out_item = out_r;

  `OABE_ASSERT(a_err_single, (ovld_r && out_r.error_code != oabe_pkg::ERR_NONE) |-> (out_r.last_of_run && out_r.ends_identifier && out_r.out_byte == 8'd0), "error beat malformed")
  `OABE_ASSERT(a_cont_bit, ovld_r |-> (out_r.out_byte[7] == !out_r.last_of_run), "continuation bit disagrees with run end")
  `OABE_ASSERT(a_take_idle, take |-> (!busy_r || done), "job taken while a run is unfinished")

endmodule

// ----- hdl/oid_arc_base128_encoder_core.sv -----
// top level of the object identifier arc base-128 encoder
// Arcs enter one per beat while full is low, through push/full, and leave as
// content bytes, one per beat, through empty/pop. An arc that yields bytes
// gives one byte per 7-bit group, 1 to 5 groups at the 31-bit arc width; a
// held first arc or a dropped arc yields no byte. The back end moves one byte
// per cycle into the result register while that register is empty or being
// popped; the front end checks and combines arcs, and a queue parks up to
// QUEUE_DEPTH jobs (2 or more) so that input keeps flowing while bytes drain.
// Error results are single zero bytes carrying the error code.
module oid_arc_base128_encoder_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  oabe_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output oabe_pkg::out_item_t out_item
);

  logic           job_push;
  logic           job_pop;
  logic           job_empty;
  oabe_pkg::job_t job_in;
  oabe_pkg::job_t job_out;

  oabe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (push && !full),
    .item     (in_item),
    .job_push (job_push),
    .job      (job_in)
  );

  oabe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_in),
    .full  (full),
    .pop   (job_pop),
    .empty (job_empty),
    .rdata (job_out)
  );

  oabe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

endmodule
